// File: rtl/gwws_pkg.sv
// Shared constants, codes and controller/datapath interface types for the word wrapper.
package gwws_pkg;

   // Character codes
   localparam logic [7:0] CH_NL = 8'd10;
   localparam logic [7:0] CH_SP = 8'd32;

   // Field and register widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int CFG_W      = 10;
   localparam int LP_W       = 11;

   localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 10'd80;

   // Output byte source select
   localparam logic [1:0] SRC_NL   = 2'd0;
   localparam logic [1:0] SRC_SP   = 2'd1;
   localparam logic [1:0] SRC_WORD = 2'd2;

   // What follows the word of an item
   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_PAR  = 2'd1;
   localparam logic [1:0] TAIL_EOS  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic       accept;
      logic       emit;
      logic       last;
      logic       word_adv;
      logic [1:0] src;
   } gwws_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       slot_free;
      logic       wrap_go;
      logic       sp_go;
      logic       word_go;
      logic [1:0] tail;
      logic       word_last;
   } gwws_status_type;

endpackage

// File: rtl/gwws_ctrl.sv
// Sequencer that accepts input beats and steps through the bytes one item emits.
module gwws_ctrl
   import gwws_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  gwws_status_type status,
   output gwws_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_NL   = 3'd1;
   localparam logic [2:0] ST_SP   = 3'd2;
   localparam logic [2:0] ST_WORD = 3'd3;
   localparam logic [2:0] ST_PAR1 = 3'd4;
   localparam logic [2:0] ST_PAR2 = 3'd5;
   localparam logic [2:0] ST_EOS  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       sp_ff, sp_in;
   logic       word_ff, word_in;
   logic [1:0] tail_ff, tail_in;

   // First remaining step of an emit plan
   function automatic logic [2:0] pick(input logic sp, input logic word, input logic [1:0] tail);
      logic [2:0] r;
      if (sp) begin
         r = ST_SP;
      end else if (word) begin
         r = ST_WORD;
      end else begin
         case (tail)
            TAIL_PAR: r = ST_PAR1;
            TAIL_EOS: r = ST_EOS;
            default:  r = ST_IDLE;
         endcase
      end
      return r;
   endfunction

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      sp_in      = sp_ff;
      word_in    = word_ff;
      tail_in    = tail_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               sp_in      = status.sp_go;
               word_in    = status.word_go;
               tail_in    = status.tail;
               state_in   = status.wrap_go ? ST_NL
                                           : pick(status.sp_go, status.word_go, status.tail);
            end
         end
         ST_NL: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_NL;
               state_in = pick(sp_ff, word_ff, tail_ff);
            end
         end
         ST_SP: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_SP;
               state_in = pick(1'b0, word_ff, tail_ff);
            end
         end
         ST_WORD: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_WORD;
               if (status.word_last) begin
                  state_in = pick(1'b0, 1'b0, tail_ff);
               end else begin
                  cmd.word_adv = 1'b1;
               end
            end
         end
         ST_PAR1: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_NL;
               state_in = ST_PAR2;
            end
         end
         ST_PAR2, ST_EOS: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_NL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Mark the final beat of the item
      cmd.last = cmd.emit && (state_in == ST_IDLE);
   end

   // Hold state and plan
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= 1'b0;
         word_ff  <= 1'b0;
         tail_ff  <= TAIL_NONE;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         word_ff  <= word_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

// File: rtl/gwws_datapath.sv
// Word store, line and flag registers, width check and the output register.
module gwws_datapath
   import gwws_pkg::*;
#(
   parameter int MAX_WORD = 56
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gwws_cmd_type          cmd,
   output gwws_status_type       status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD);

   logic [7:0]       word_mem [MAX_WORD];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LP_W-1:0]  lp_ff, lp_in;
   logic [CFG_W-1:0] width_ff;
   logic             nl_seen_ff, nl_seen_in;
   logic             par_done_ff, par_done_in;
   logic             err_ff, err_in;
   logic             ovf_ff, ovf_in;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff, out_err_ff, out_ovf_ff;

   logic [7:0]      in_byte;
   logic            eos, is_white, is_nl, flush, wrap, paragraph, mem_we, mem_re;
   logic [LP_W-1:0] lp_gap, need, lp_word;

   assign in_byte  = req_tdata[7:0];
   assign eos      = req_tuser;
   assign is_white = in_byte inside {[8'd9:8'd13], CH_SP};
   assign is_nl    = (in_byte == CH_NL);

   // Greedy width check for the held word
   assign flush     = eos || (is_white && (len_ff != '0));
   assign lp_gap    = (lp_ff != '0) ? LP_W'(1) : '0;
   assign need      = lp_ff + LP_W'(len_ff) + lp_gap;
   assign wrap      = (need > LP_W'(width_ff));
   assign lp_word   = wrap ? LP_W'(len_ff) : need;
   assign paragraph = !eos && is_nl && nl_seen_ff && !par_done_ff;

   // Status to the sequencer
   always_comb begin
      status.slot_free = !out_valid_ff || rsp_tready;
      status.wrap_go   = flush && wrap;
      status.sp_go     = flush && !wrap && (lp_ff != '0);
      status.word_go   = flush && (len_ff != '0);
      status.tail      = eos ? TAIL_EOS : (paragraph ? TAIL_PAR : TAIL_NONE);
      status.word_last = ((LEN_W'(rd_idx_ff) + LEN_W'(1)) == cnt_ff);
   end

   // Update line state on an accepted beat
   always_comb begin
      lp_in       = lp_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      nl_seen_in  = nl_seen_ff;
      par_done_in = par_done_ff;
      err_in      = err_ff;
      ovf_in      = ovf_ff;
      if (cmd.accept) begin
         if (eos) begin
            cnt_in      = len_ff;
            len_in      = '0;
            lp_in       = '0;
            nl_seen_in  = 1'b0;
            par_done_in = 1'b0;
            if (lp_word > LP_W'(width_ff)) begin
               err_in = 1'b1;
            end
         end else if (is_white) begin
            if (flush) begin
               cnt_in = len_ff;
               len_in = '0;
               lp_in  = lp_word;
               if (lp_word > LP_W'(width_ff)) begin
                  err_in = 1'b1;
               end
            end
            if (is_nl) begin
               if (!nl_seen_ff) begin
                  nl_seen_in = 1'b1;
               end else if (!par_done_ff) begin
                  nl_seen_in  = 1'b0;
                  par_done_in = 1'b1;
                  lp_in       = '0;
               end
            end
         end else begin
            if (len_ff < MAX_LEN) begin
               len_in = len_ff + LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            nl_seen_in  = 1'b0;
            par_done_in = 1'b0;
         end
      end
   end

   // Word store read pointer: restart on accept, advance per word beat
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.accept) begin
         rd_idx_in = '0;
      end else if (cmd.word_adv) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   assign mem_we = cmd.accept && !eos && !is_white && (len_ff < MAX_LEN);
   assign mem_re = cmd.accept || cmd.word_adv;

   // Word store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[len_ff[IDX_W-1:0]] <= in_byte;
      end
      if (mem_re) begin
         rd_data_ff <= word_mem[rd_idx_in];
      end
   end

   // Control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         lp_ff       <= '0;
         nl_seen_ff  <= 1'b0;
         par_done_ff <= 1'b0;
         err_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         width_ff    <= LINE_WIDTH_RESET;
      end else begin
         len_ff      <= len_in;
         lp_ff       <= lp_in;
         nl_seen_ff  <= nl_seen_in;
         par_done_ff <= par_done_in;
         err_ff      <= err_in;
         ovf_ff      <= ovf_in;
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
      end
   end

   // Word count and read pointer
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      rd_idx_ff <= rd_idx_in;
   end

   // Output register valid: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.src)
            SRC_SP:   out_byte_ff <= CH_SP;
            SRC_WORD: out_byte_ff <= rd_data_ff;
            default:  out_byte_ff <= CH_NL;
         endcase
         out_last_ff <= cmd.last;
         out_err_ff  <= err_ff;
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'b0, out_ovf_ff, out_err_ff, out_byte_ff};

endmodule

// File: rtl/greedy_word_wrap_stream.sv
// Top level of the streaming greedy word wrapper.
//
// Input channel req_*: one beat per text byte (req_tdata) or, with req_tuser
// high, an end-of-stream beat that flushes the held word and a final newline.
// Output channel rsp_*: one beat per emitted byte with the sticky width and
// word-overflow flags; rsp_tlast marks the last beat caused by an input beat.
// The user writes line_width through csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
//
// A beat that emits nothing leaves the sequencer idle. A beat that emits N bytes is
// accepted and then sends one byte per cycle, unless the receiver stalls, through
// the single output register; the sequencer state is registered at the accepting
// edge, before the first byte is loaded. The next input beat is taken in the cycle
// after the last byte is loaded, while that byte may still wait in the output register.
// The word store (MAX_WORD bytes) has one read port with registered data and
// is prefetched at acceptance, so word bytes flow back to back.
// Reset clears the line state, flags and output valid and sets line_width to
// 80; the word store is not cleared. A stalled receiver holds the current
// beat and stops the sequencer; no input is taken until the item is done.
module greedy_word_wrap_stream
   import gwws_pkg::*;
#(
   parameter int MAX_WORD = 56
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic                  req_tuser,   // [0] end_of_stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] out_byte, [8] width_error,
                                              // [9] word_overflow, [15:10] zero
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data  // line_width
);

   gwws_cmd_type    cmd;
   gwws_status_type status;

   gwws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gwws_datapath #(
      .MAX_WORD (MAX_WORD)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: rtl/gwws_checker.sv
// Port-level checks for the word wrapper and their binding to the top level.
module gwws_checker
   import gwws_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // Output goes quiet after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   // No new input while an item still has bytes to send
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of an item");

   // Width error flag is sticky
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |=> !rsp_tvalid || rsp_tdata[8])
      else $error("width_error fell");

   // Word overflow flag is sticky
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |=> !rsp_tvalid || rsp_tdata[9])
      else $error("word_overflow fell");

endmodule

bind greedy_word_wrap_stream gwws_checker u_gwws_checker (.*);

// File: tb/sv/greedy_word_wrap_stream_test.sv
// Self-checking stream testbench for the greedy word wrapper.
`timescale 1ns / 100ps

module greedy_word_wrap_stream_test;
   import gwws_pkg::*;

   localparam int MAX_WORD    = 56;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE      = 12;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 80;
   localparam int N_PHASES    = 6;

   // Whitespace codes besides newline and space
   localparam logic [7:0] CH_HT = 8'd9;
   localparam logic [7:0] CH_VT = 8'd11;
   localparam logic [7:0] CH_FF = 8'd12;
   localparam logic [7:0] CH_CR = 8'd13;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } text_beat_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       width_err;
      logic       overflow;
   } wrapped_byte_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = LINE_WIDTH_RESET;

   // Stimulus, expectations and run control
   text_beat_type    text_beats_to_send[$];
   wrapped_byte_type wrapped_bytes_due[$];
   logic [7:0]       emit_now[$];
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   logic             pressure_armed = 1'b0;
   logic             pressure_done  = 1'b0;
   int unsigned      hold_left      = 0;
   int unsigned      quiet_cycles   = 0;
   int unsigned      errors         = 0;
   int unsigned      beats_taken    = 0;
   int unsigned      bytes_checked  = 0;
   int unsigned      width_writes   = 0;
   int unsigned      par_breaks     = 0;
   int unsigned      truncations    = 0;

   // Wrapper state mirrored by the predictor
   logic [7:0]       m_word[MAX_WORD];
   int unsigned      m_word_len  = 0;
   int unsigned      m_line_pos  = 0;
   logic             m_nl_seen   = 1'b0;
   logic             m_par_done  = 1'b0;
   logic             m_width_err = 1'b0;
   logic             m_overflow  = 1'b0;
   logic [CFG_W-1:0] m_width     = LINE_WIDTH_RESET;

   greedy_word_wrap_stream i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] in_byte
      .req_tuser   (req_tuser),    // [0] end_of_stream
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] out_byte, [8] width_error, [9] word_overflow
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_space(input logic [7:0] b);
      return (b >= CH_HT && b <= CH_CR) || b == CH_SP;
   endfunction

   // Write out the held word with the greedy fit rule
   function automatic void flush_held_word();
      int unsigned need;
      int unsigned i;
      need = m_line_pos + m_word_len + ((m_line_pos != 0) ? 1 : 0);
      if (need > m_width) begin
         emit_now.push_back(CH_NL);
         m_line_pos = 0;
      end
      if (m_line_pos != 0) begin
         emit_now.push_back(CH_SP);
         m_line_pos++;
      end
      for (i = 0; i < m_word_len; i++)
         emit_now.push_back(m_word[i]);
      m_line_pos += m_word_len;
      if (m_line_pos > m_width)
         m_width_err = 1'b1;
      m_word_len = 0;
   endfunction

   // Advance the wrapper state by one text beat and queue the bytes it yields
   function automatic void wrap_text_beat(input logic [7:0] b, input logic eos);
      wrapped_byte_type o;
      int               k;
      emit_now.delete();
      if (eos) begin
         flush_held_word();
         emit_now.push_back(CH_NL);
         m_line_pos = 0;
         m_nl_seen  = 1'b0;
         m_par_done = 1'b0;
      end else if (is_space(b)) begin
         if (m_word_len != 0)
            flush_held_word();
         if (b == CH_NL) begin
            if (!m_nl_seen) begin
               m_nl_seen = 1'b1;
            end else if (!m_par_done) begin
               emit_now.push_back(CH_NL);
               emit_now.push_back(CH_NL);
               m_line_pos = 0;
               m_nl_seen  = 1'b0;
               m_par_done = 1'b1;
               par_breaks++;
            end
         end
      end else begin
         if (m_word_len < MAX_WORD) begin
            m_word[m_word_len] = b;
            m_word_len++;
         end else begin
            m_overflow = 1'b1;
            truncations++;
         end
         m_nl_seen  = 1'b0;
         m_par_done = 1'b0;
      end
      for (k = 0; k < emit_now.size(); k++) begin
         o.ch        = emit_now[k];
         o.last      = (k == emit_now.size() - 1);
         o.width_err = m_width_err;
         o.overflow  = m_overflow;
         wrapped_bytes_due.push_back(o);
      end
   endfunction

   // Drive text beats; hold a beat until it is taken
   always @(posedge clock) begin
      text_beat_type nxt;
      logic          load;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            wrap_text_beat(req_tdata, req_tuser);
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            load = text_beats_to_send.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct;
            if (load) begin
               nxt = text_beats_to_send.pop_front();
               req_tdata <= nxt.ch;
               req_tuser <= nxt.eos;
            end
            req_tvalid <= load;
         end
      end
   end

   // Receiver ready: one long hold-off when armed, random stalls otherwise
   always @(posedge clock) begin
      if (pressure_armed && !pressure_done) begin
         hold_left     <= HOLD_CYCLES;
         pressure_done <= 1'b1;
         rsp_tready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check each output beat against the oldest expected byte
   always @(posedge clock) begin
      wrapped_byte_type exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (wrapped_bytes_due.size() == 0) begin
            $display("%0t: unexpected output beat byte=%h last=%b werr=%b ovf=%b", $time,
                     rsp_tdata[7:0], rsp_tlast, rsp_tdata[8], rsp_tdata[9]);
            errors++;
         end else begin
            exp_b = wrapped_bytes_due.pop_front();
            if (rsp_tdata[7:0] !== exp_b.ch || rsp_tlast !== exp_b.last ||
                rsp_tdata[8] !== exp_b.width_err || rsp_tdata[9] !== exp_b.overflow) begin
               $display("%0t: mismatch expected byte=%h last=%b werr=%b ovf=%b", $time,
                        exp_b.ch, exp_b.last, exp_b.width_err, exp_b.overflow);
               $display("%0t:          actual   byte=%h last=%b werr=%b ovf=%b", $time,
                        rsp_tdata[7:0], rsp_tlast, rsp_tdata[8], rsp_tdata[9]);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic void queue_beat(input logic [7:0] ch, input logic eos);
      text_beat_type t;
      t.ch  = ch;
      t.eos = eos;
      text_beats_to_send.push_back(t);
   endfunction

   function automatic logic [7:0] pick_word_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (is_space(c))
         c = 8'($urandom_range(255));
      return c;
   endfunction

   function automatic logic [7:0] pick_blank();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70)
         return CH_SP;
      else if (r < 80)
         return CH_HT;
      else if (r < 85)
         return CH_VT;
      else if (r < 90)
         return CH_FF;
      else
         return CH_CR;
   endfunction

   // Mostly words with random content and mixed separators, some noise
   function automatic void fill_random_text(input int unsigned n_items);
      int unsigned goal;
      int unsigned len;
      int unsigned r;
      int unsigned i;
      goal = text_beats_to_send.size() + n_items;
      while (text_beats_to_send.size() < goal) begin
         if ($urandom_range(99) < 12) begin
            if ($urandom_range(99) < 15)
               queue_beat(8'($urandom_range(255)), 1'b1);
            else
               queue_beat(8'($urandom_range(255)), 1'b0);
         end else begin
            r = $urandom_range(99);
            if (r < 80)
               len = $urandom_range(1, 9);
            else if (r < 95)
               len = $urandom_range(10, 40);
            else
               len = $urandom_range(MAX_WORD - 2, MAX_WORD + 6);
            for (i = 0; i < len; i++)
               queue_beat(pick_word_char(), 1'b0);
            r = $urandom_range(99);
            if (r < 70) begin
               queue_beat(pick_blank(), 1'b0);
            end else if (r < 82) begin
               queue_beat(CH_NL, 1'b0);
            end else if (r < 90) begin
               queue_beat(CH_NL, 1'b0);
               queue_beat(CH_NL, 1'b0);
            end else if (r < 94) begin
               queue_beat(CH_NL, 1'b0);
               queue_beat(CH_NL, 1'b0);
               queue_beat(CH_NL, 1'b0);
            end else if (r < 97) begin
               queue_beat(CH_SP, 1'b0);
               queue_beat(pick_blank(), 1'b0);
            end else begin
               queue_beat(8'h00, 1'b1);
            end
         end
      end
   endfunction

   // Wait until every beat is sent and answered, then let the block settle
   task automatic drain_block();
      while (text_beats_to_send.size() != 0 || req_tvalid || wrapped_bytes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_line_width(input logic [CFG_W-1:0] w);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      m_width = w;
      width_writes++;
   endtask

   initial begin
      logic [CFG_W-1:0] widths[N_PHASES];
      int unsigned      p;
      widths[0] = 10'd1023;
      widths[1] = 10'd1;
      widths[2] = 10'd0;
      widths[3] = 10'($urandom_range(2, 1022));
      widths[4] = 10'd12;
      widths[5] = LINE_WIDTH_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed text at the reset width: empty stream, byte extremes,
      // every whitespace code, paragraph break once, trailing space on flush
      queue_beat(8'h00, 1'b1);
      queue_beat("a", 1'b0);
      queue_beat("b", 1'b0);
      queue_beat(CH_SP, 1'b0);
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'h00, 1'b0);
      queue_beat(CH_VT, 1'b0);
      queue_beat(CH_HT, 1'b0);
      queue_beat(8'h7F, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_beat(CH_NL, 1'b0);
      queue_beat(CH_NL, 1'b0);
      queue_beat(CH_NL, 1'b0);
      queue_beat("q", 1'b0);
      queue_beat(CH_FF, 1'b0);
      queue_beat(CH_CR, 1'b0);
      queue_beat(8'hFF, 1'b1);
      queue_beat("z", 1'b0);
      queue_beat(8'h00, 1'b1);
      queue_beat(CH_SP, 1'b0);
      drain_block();

      // Random phases over widths and idle patterns
      for (p = 0; p < N_PHASES; p++) begin
         write_line_width(widths[p]);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 54;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 54;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         fill_random_text(PHASE_ITEMS);
         if (p == 0)
            pressure_armed <= 1'b1;
         drain_block();
      end

      $display("Run covered %0d text beats and %0d output beats over %0d line widths (0 to 1023),",
               beats_taken, bytes_checked, width_writes + 1);
      $display("with %0d paragraph breaks, %0d dropped word bytes and a long receiver hold-off.",
               par_breaks, truncations);
      if (errors == 0 && wrapped_bytes_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
